// ----- design/button_press_repeat_detector_unit_macros.svh -----
// ----------------------------------------------------------------------------
// button press repeat detector assertion macros
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_REPEAT_DETECTOR_UNIT_MACROS_SVH
`define BUTTON_PRESS_REPEAT_DETECTOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BPRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define BPRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define BPRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define BPRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/bprd_pkg.sv -----
// ----------------------------------------------------------------------------
// bprd_pkg
// shared types and constants of the button press repeat detector
// ----------------------------------------------------------------------------
`default_nettype none

package bprd_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_ACTIVE_LEVEL  = 2'd0;
	localparam logic [1:0] CFG_PRESS_DELAY   = 2'd1;
	localparam logic [1:0] CFG_REPEAT_START  = 2'd2;
	localparam logic [1:0] CFG_REPEAT_PERIOD = 2'd3;

	// configuration reset values
	localparam logic        RST_ACTIVE_LEVEL  = 1'b0;
	localparam logic [15:0] RST_PRESS_DELAY   = 16'd50;
	localparam logic [15:0] RST_REPEAT_START  = 16'd1000;
	localparam logic [15:0] RST_REPEAT_PERIOD = 16'd100;

	// item kinds
	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	typedef struct packed {
		logic        active_level;
		logic [15:0] press_delay_ms;
		logic [15:0] repeat_start_ms;
		logic [15:0] repeat_period_ms;
	} cfg_t;

	typedef struct packed {
		logic        kind;
		logic        button_level;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		logic        fired;
		logic        evt_clicked;
		logic        evt_repeated;
		logic        evt_released;
		logic        st_pressed;
		logic        st_released;
		logic        st_repeated;
		logic [15:0] clicks;
	} result_t;

endpackage

`default_nettype wire

// ----- design/button_press_repeat_detector_unit.sv -----
// ----------------------------------------------------------------------------
// button_press_repeat_detector_unit
// debounced button press detection with auto-repeat clicks
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word per cycle: an update
//   carrying the raw pin level and a millisecond timestamp, or a clear of
//   the sticky event flags. Output channel (out_valid/out_ready) returns
//   exactly one result word per input word, in order.
//   Configuration channel (cfg_valid/cfg_ready) writes one register per
//   cycle, selected by cfg_index; cfg_ready is always high. Write it only
//   while no words are in flight.
//   Path: an accepted word sits in the input register; its result is
//   loaded into the result register, where it waits to be taken.
//   Throughput: one word per cycle while the receiver does not stall,
//   set by the combinational phase update between the input register
//   and the result register.
//   A stalled receiver holds the result register; one more word may wait
//   in the input register, after which in_ready drops.
//   Reset clears the phase machine, flags, click count and timer mark and
//   loads the default active level and hold times.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_repeat_detector_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic        button_level,
	input  wire logic [31:0] now_ms,
	// output channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             fired,
	output logic             evt_clicked,
	output logic             evt_repeated,
	output logic             evt_released,
	output logic             st_pressed,
	output logic             st_released,
	output logic             st_repeated,
	output logic [15:0]      clicks,
	// configuration channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import bprd_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;
	logic    step;

	// handshake flow through the two register stages
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_level     <= RST_ACTIVE_LEVEL;
			cfg_q.press_delay_ms   <= RST_PRESS_DELAY;
			cfg_q.repeat_start_ms  <= RST_REPEAT_START;
			cfg_q.repeat_period_ms <= RST_REPEAT_PERIOD;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ACTIVE_LEVEL:  cfg_q.active_level     <= cfg_data[0];
				CFG_PRESS_DELAY:   cfg_q.press_delay_ms   <= cfg_data;
				CFG_REPEAT_START:  cfg_q.repeat_start_ms  <= cfg_data;
				CFG_REPEAT_PERIOD: cfg_q.repeat_period_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.kind         <= kind;
			item_s1.button_level <= button_level;
			item_s1.now_ms       <= now_ms;
		end
	end

	// phase machine and flags
	bprd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	// output ports
	assign out_valid    = out_valid_q;
	assign fired        = res_q.fired;
	assign evt_clicked  = res_q.evt_clicked;
	assign evt_repeated = res_q.evt_repeated;
	assign evt_released = res_q.evt_released;
	assign st_pressed   = res_q.st_pressed;
	assign st_released  = res_q.st_released;
	assign st_repeated  = res_q.st_repeated;
	assign clicks       = res_q.clicks;

endmodule

`default_nettype wire

// ----- design/bprd_core.sv -----
// ----------------------------------------------------------------------------
// bprd_core
// press/repeat phase machine and flag state, one item per step
// ----------------------------------------------------------------------------
`default_nettype none

`include "button_press_repeat_detector_unit_macros.svh"

module bprd_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire bprd_pkg::item_t  item,
	input  wire bprd_pkg::cfg_t   cfg,
	output bprd_pkg::result_t     res
);
	import bprd_pkg::*;

	typedef enum logic [1:0] {
		PH_WAIT,
		PH_PRESSED,
		PH_RSTART,
		PH_REPEAT
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [31:0] mark_q, mark_d;
	logic        evt_clk_q, evt_rep_q, evt_rel_q;
	logic        evt_clk_d, evt_rep_d, evt_rel_d;
	logic        st_prs_q, st_rel_q, st_rep_q;
	logic        st_prs_d, st_rel_d, st_rep_d;
	logic [15:0] clicks_q, clicks_d;
	logic        fire;
	logic        down;
	logic [31:0] elapsed;
	logic [15:0] hold_ms;
	logic        hold_done;

	// hold time check against the last mark, wrapping subtraction
	assign down    = (item.button_level == cfg.active_level);
	assign elapsed = item.now_ms - mark_q;

	always_comb begin
		case (phase_q)
			PH_PRESSED: hold_ms = cfg.press_delay_ms;
			PH_RSTART:  hold_ms = cfg.repeat_start_ms;
			default:    hold_ms = cfg.repeat_period_ms;
		endcase
	end

	assign hold_done = (elapsed >= {16'd0, hold_ms});

	// next state for one item
	always_comb begin
		phase_d   = phase_q;
		mark_d    = mark_q;
		evt_clk_d = evt_clk_q;
		evt_rep_d = evt_rep_q;
		evt_rel_d = evt_rel_q;
		st_prs_d  = st_prs_q;
		st_rel_d  = st_rel_q;
		st_rep_d  = st_rep_q;
		clicks_d  = clicks_q;
		fire      = 1'b0;
		if (item.kind == KIND_CLEAR) begin
			evt_clk_d = 1'b0;
			evt_rep_d = 1'b0;
			evt_rel_d = 1'b0;
		end else begin
			case (phase_q)
				PH_WAIT: begin
					if (down) begin
						phase_d  = PH_PRESSED;
						mark_d   = item.now_ms;
						clicks_d = 16'd0;
					end
				end
				PH_PRESSED: begin
					if (down) begin
						if (hold_done) begin
							fire      = 1'b1;
							phase_d   = PH_RSTART;
							evt_clk_d = 1'b1;
							st_prs_d  = 1'b1;
						end
					end else begin
						phase_d = PH_WAIT;
						if (st_prs_q) begin
							evt_rel_d = 1'b1;
							st_rel_d  = 1'b1;
							st_prs_d  = 1'b0;
							st_rep_d  = 1'b0;
						end
					end
				end
				default: begin
					// repeat-start and repeating share the click path
					if (down) begin
						if (hold_done) begin
							fire      = 1'b1;
							phase_d   = PH_REPEAT;
							evt_clk_d = 1'b1;
							evt_rep_d = 1'b1;
							st_rep_d  = 1'b1;
						end
					end else begin
						phase_d = PH_PRESSED;
					end
				end
			endcase
			// every click restarts the hold timer and bumps the count
			if (fire) begin
				mark_d   = item.now_ms;
				clicks_d = clicks_q + 16'd1;
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_WAIT;
			mark_q    <= 32'd0;
			evt_clk_q <= 1'b0;
			evt_rep_q <= 1'b0;
			evt_rel_q <= 1'b0;
			st_prs_q  <= 1'b0;
			st_rel_q  <= 1'b0;
			st_rep_q  <= 1'b0;
			clicks_q  <= 16'd0;
		end else if (step) begin
			phase_q   <= phase_d;
			mark_q    <= mark_d;
			evt_clk_q <= evt_clk_d;
			evt_rep_q <= evt_rep_d;
			evt_rel_q <= evt_rel_d;
			st_prs_q  <= st_prs_d;
			st_rel_q  <= st_rel_d;
			st_rep_q  <= st_rep_d;
			clicks_q  <= clicks_d;
		end
	end

	// result word shows the state after the item
	always_comb begin
		res.fired        = fire;
		res.evt_clicked  = evt_clk_d;
		res.evt_repeated = evt_rep_d;
		res.evt_released = evt_rel_d;
		res.st_pressed   = st_prs_d;
		res.st_released  = st_rel_d;
		res.st_repeated  = st_rep_d;
		res.clicks       = clicks_d;
	end

	// a click always advances the count by one
	`BPRD_ASSERT_NOW(a_fire_counts, clk, arst_n, fire, clicks_d == clicks_q + 16'd1)
	// no click while waiting for a press
	`BPRD_ASSERT_NOW(a_wait_no_fire, clk, arst_n, phase_q == PH_WAIT, !fire)
	// a clear word empties the sticky events
	`BPRD_ASSERT_NEXT(a_clear_events, clk, arst_n, step && item.kind == KIND_CLEAR,
		!evt_clk_q && !evt_rep_q && !evt_rel_q)
	// released status is never dropped
	`BPRD_ASSERT_NEXT(a_released_sticks, clk, arst_n, st_rel_q, st_rel_q)
	// state only moves on a step
	`BPRD_ASSERT_NEXT(a_hold_idle, clk, arst_n, !step, $stable(clicks_q) && $stable(mark_q))

endmodule

`default_nettype wire
